// File: hw/rtl/jsp_pkg.sv
// ----------------------------------------------------------------------------
// jsp_pkg - shared types and constants of the Jacobi stencil point update
// Field widths, internal datapath widths, register map codes, reset values and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package jsp_pkg;

  // Field widths
  localparam int VAL_W    = 48;   // signed Q16.32 grid value
  localparam int SUM_W    = 49;   // sum of two neighbors, also value difference
  localparam int COEF_W   = 47;   // unsigned Q15.32 coefficient and grid step
  localparam int INV_W    = 48;   // unsigned Q0.48 reciprocal
  localparam int GAIN_W   = 24;   // integer gain a
  localparam int IDX_W    = 7;    // grid index

  // Datapath widths
  localparam int OFF_W    = IDX_W + COEF_W;  // index * step
  localparam int CRD_W    = OFF_W + 2;       // origin + offset, signed
  localparam int HALF_W   = 24;              // partial product slice
  localparam int PP_W     = 50;              // 25 x 25 signed partial product
  localparam int SQ_W     = 96;              // squared coordinate, Q32.64
  localparam int PROD_W   = 96;              // coefficient times neighbor sum
  localparam int NUMP_W   = 98;              // sum of the three axis terms
  localparam int AR2_W    = 120;             // gain times squared radius
  localparam int NUM_W    = 122;             // signed numerator, Q.64
  localparam int MAG_W    = 121;             // numerator magnitude
  localparam int CHK_W    = 25;              // magnitude slice for the reciprocal multiply
  localparam int NCHK     = 5;               // slices over the magnitude
  localparam int IP_W     = CHK_W + HALF_W;  // slice times reciprocal half
  localparam int ACC_W    = 150;             // one reciprocal half times magnitude
  localparam int P_W      = 170;             // full product, Q.112
  localparam int RND_SH   = 80;              // Q.112 to Q.32
  localparam int Q_W      = P_W - RND_SH;    // rounded magnitude

  // Configuration port
  localparam int PDATA_W  = 64;
  localparam int PADDR_W  = 6;
  localparam int ADDR_LSB = 3;

  typedef enum logic [PADDR_W-ADDR_LSB-1:0] {
    REG_COEF_X   = 3'd0,
    REG_COEF_Y   = 3'd1,
    REG_COEF_Z   = 3'd2,
    REG_INV_DEN  = 3'd3,
    REG_STEP     = 3'd4,
    REG_ORIGIN   = 3'd5,
    REG_GAIN_A   = 3'd6
  } reg_idx_t;

  // Reset values
  localparam logic [COEF_W-1:0]        COEF_RST   = 47'd10523743617024;
  localparam logic [INV_W-1:0]         INV_RST    = 48'd277397250;
  localparam logic [COEF_W-1:0]        STEP_RST   = 47'd86767016;
  localparam logic signed [VAL_W-1:0]  ORIGIN_RST = 48'shFFFF_0000_0000;
  localparam logic [GAIN_W-1:0]        GAIN_RST   = 24'd1000000;

  // Value limits and the constant term 6 in Q.64
  localparam logic signed [VAL_W-1:0]  VAL_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0]  VAL_MIN    = 48'sh8000_0000_0000;
  localparam logic signed [NUM_W-1:0]  SIX_Q64    = {58'd6, 64'd0};

endpackage

`default_nettype wire

// File: hw/rtl/jacobi_stencil_point_update.sv
// ----------------------------------------------------------------------------
// jacobi_stencil_point_update - one Jacobi update of a 3-D grid point
// Seven-point stencil for lap(u) - a*u = 6 - a*r^2 in signed Q16.32, with
// exact products, round to nearest (ties away from zero) and saturation.
//
//   Channel   Direction  Handshake               Payload
//   in_       in         start, busy             center_prev, six neighbors, indices
//   out_      out        out_valid (strobe)      new_value, abs_change, saturated
//   cfg_      in/out     psel, penable, pready   paddr, pwdata, prdata (64 bit)
//
// One transaction is accepted per cycle out of reset; the result goes through
// twelve datapath stages and the output register.
// Wide products are split into pieces of 24 or 25 bits, summed in later stages.
// busy is high only during reset; no clearing pass is needed.
// The receiver cannot stall: every result is shown for one cycle.
// The user must write registers only with no transaction in flight; it is not checked.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_stencil_point_update (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_center_prev,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_x_plus,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_x_minus,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_y_plus,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_y_minus,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_z_plus,
  input  logic signed [jsp_pkg::VAL_W-1:0]    in_z_minus,
  input  logic        [jsp_pkg::IDX_W-1:0]    in_index_x,
  input  logic        [jsp_pkg::IDX_W-1:0]    in_index_y,
  input  logic        [jsp_pkg::IDX_W-1:0]    in_index_z,
  // result channel
  output logic                                out_valid,
  output logic signed [jsp_pkg::VAL_W-1:0]    out_new_value,
  output logic        [jsp_pkg::COEF_W-1:0]   out_abs_change,
  output logic                                out_saturated,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [jsp_pkg::PADDR_W-1:0]  paddr,
  input  logic        [jsp_pkg::PDATA_W-1:0]  pwdata,
  output logic        [jsp_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  localparam int VAL_W  = jsp_pkg::VAL_W;
  localparam int SUM_W  = jsp_pkg::SUM_W;
  localparam int COEF_W = jsp_pkg::COEF_W;
  localparam int INV_W  = jsp_pkg::INV_W;
  localparam int GAIN_W = jsp_pkg::GAIN_W;
  localparam int IDX_W  = jsp_pkg::IDX_W;
  localparam int OFF_W  = jsp_pkg::OFF_W;
  localparam int CRD_W  = jsp_pkg::CRD_W;
  localparam int HALF_W = jsp_pkg::HALF_W;
  localparam int PP_W   = jsp_pkg::PP_W;
  localparam int SQ_W   = jsp_pkg::SQ_W;
  localparam int PROD_W = jsp_pkg::PROD_W;
  localparam int NUMP_W = jsp_pkg::NUMP_W;
  localparam int AR2_W  = jsp_pkg::AR2_W;
  localparam int NUM_W  = jsp_pkg::NUM_W;
  localparam int MAG_W  = jsp_pkg::MAG_W;
  localparam int CHK_W  = jsp_pkg::CHK_W;
  localparam int NCHK   = jsp_pkg::NCHK;
  localparam int IP_W   = jsp_pkg::IP_W;
  localparam int ACC_W  = jsp_pkg::ACC_W;
  localparam int P_W    = jsp_pkg::P_W;
  localparam int RND_SH = jsp_pkg::RND_SH;
  localparam int Q_W    = jsp_pkg::Q_W;
  localparam int PDATA_W = jsp_pkg::PDATA_W;
  localparam int PADDR_W = jsp_pkg::PADDR_W;
  localparam int ADDR_LSB = jsp_pkg::ADDR_LSB;

  localparam int NAX    = 3;               // axes
  localparam int NSTG   = 12;              // datapath stages before the output register
  localparam int LAT    = NSTG + 1;        // accept edge to result edge
  localparam int PADM_W = CHK_W * NCHK;    // padded magnitude

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0]       coef_x_r, coef_y_r, coef_z_r;
  logic [INV_W-1:0]        inv_den_r;
  logic [COEF_W-1:0]       grid_step_r;
  logic signed [VAL_W-1:0] grid_origin_r;
  logic [GAIN_W-1:0]       gain_a_r;
  logic                    cfg_wr;
  jsp_pkg::reg_idx_t       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = jsp_pkg::reg_idx_t'(paddr[PADDR_W-1:ADDR_LSB]);

  // Write the addressed register at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r      <= jsp_pkg::COEF_RST;
      coef_y_r      <= jsp_pkg::COEF_RST;
      coef_z_r      <= jsp_pkg::COEF_RST;
      inv_den_r     <= jsp_pkg::INV_RST;
      grid_step_r   <= jsp_pkg::STEP_RST;
      grid_origin_r <= jsp_pkg::ORIGIN_RST;
      gain_a_r      <= jsp_pkg::GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        jsp_pkg::REG_COEF_X:  coef_x_r      <= pwdata[COEF_W-1:0];
        jsp_pkg::REG_COEF_Y:  coef_y_r      <= pwdata[COEF_W-1:0];
        jsp_pkg::REG_COEF_Z:  coef_z_r      <= pwdata[COEF_W-1:0];
        jsp_pkg::REG_INV_DEN: inv_den_r     <= pwdata[INV_W-1:0];
        jsp_pkg::REG_STEP:    grid_step_r   <= pwdata[COEF_W-1:0];
        jsp_pkg::REG_ORIGIN:  grid_origin_r <= $signed(pwdata[VAL_W-1:0]);
        jsp_pkg::REG_GAIN_A:  gain_a_r      <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    unique case (cfg_idx)
      jsp_pkg::REG_COEF_X:  prdata = PDATA_W'(coef_x_r);
      jsp_pkg::REG_COEF_Y:  prdata = PDATA_W'(coef_y_r);
      jsp_pkg::REG_COEF_Z:  prdata = PDATA_W'(coef_z_r);
      jsp_pkg::REG_INV_DEN: prdata = PDATA_W'(inv_den_r);
      jsp_pkg::REG_STEP:    prdata = PDATA_W'(grid_step_r);
      jsp_pkg::REG_ORIGIN:  prdata = PDATA_W'($unsigned(grid_origin_r));
      jsp_pkg::REG_GAIN_A:  prdata = PDATA_W'(gain_a_r);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake and valid line
  // --------------------------------------------------------------------------
  logic            busy_r;
  logic            accept;
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Hold busy through reset, advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[NSTG-2:0], accept};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // Carry the previous center value alongside the datapath
  logic signed [VAL_W-1:0] prev_r [NSTG];

  always_ff @(posedge clk) begin
    prev_r[0] <= in_center_prev;
    for (int i = 1; i < NSTG; i++) begin
      prev_r[i] <= prev_r[i-1];
    end
  end

  // Per-axis views of the inputs and coefficients
  logic signed [VAL_W-1:0] nb_plus  [NAX];
  logic signed [VAL_W-1:0] nb_minus [NAX];
  logic [IDX_W-1:0]        idx_a    [NAX];
  logic [COEF_W-1:0]       coef_a   [NAX];

  assign nb_plus[0]  = in_x_plus;
  assign nb_plus[1]  = in_y_plus;
  assign nb_plus[2]  = in_z_plus;
  assign nb_minus[0] = in_x_minus;
  assign nb_minus[1] = in_y_minus;
  assign nb_minus[2] = in_z_minus;
  assign idx_a[0]    = in_index_x;
  assign idx_a[1]    = in_index_y;
  assign idx_a[2]    = in_index_z;
  assign coef_a[0]   = coef_x_r;
  assign coef_a[1]   = coef_y_r;
  assign coef_a[2]   = coef_z_r;

  // --------------------------------------------------------------------------
  // Stage 1: neighbor sums and index offsets
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] s1_sum_nxt [NAX], s1_sum_r [NAX];
  logic [OFF_W-1:0]        s1_off_nxt [NAX], s1_off_r [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      s1_sum_nxt[a] = SUM_W'(nb_plus[a]) + SUM_W'(nb_minus[a]);
      s1_off_nxt[a] = OFF_W'(idx_a[a]) * OFF_W'(grid_step_r);
    end
  end

  always_ff @(posedge clk) begin
    s1_sum_r <= s1_sum_nxt;
    s1_off_r <= s1_off_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 2: coordinates, clipped, as magnitudes
  // --------------------------------------------------------------------------
  logic signed [CRD_W-1:0] crd [NAX];
  logic [VAL_W-1:0]        s2_cmag_nxt [NAX], s2_cmag_r [NAX];
  logic signed [SUM_W-1:0] s2_sum_r [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      crd[a] = CRD_W'(grid_origin_r) + $signed({2'b00, s1_off_r[a]});
      if (crd[a] > jsp_pkg::VAL_MAX) begin
        s2_cmag_nxt[a] = $unsigned(jsp_pkg::VAL_MAX);
      end else if (crd[a] < jsp_pkg::VAL_MIN) begin
        s2_cmag_nxt[a] = $unsigned(jsp_pkg::VAL_MIN);
      end else if (crd[a][CRD_W-1]) begin
        s2_cmag_nxt[a] = VAL_W'(-crd[a]);
      end else begin
        s2_cmag_nxt[a] = VAL_W'(crd[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_cmag_r <= s2_cmag_nxt;
    s2_sum_r  <= s1_sum_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: partial products of squares and axis terms
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0]         s3_sq_nxt [NAX][3], s3_sq_r [NAX][3];
  logic signed [CHK_W-1:0]  a_lo [NAX], a_hi [NAX], b_lo [NAX], b_hi [NAX];
  logic signed [PP_W-1:0]   s3_pp_nxt [NAX][4], s3_pp_r [NAX][4];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      // square: low*low, low*high, high*high
      s3_sq_nxt[a][0] = VAL_W'(s2_cmag_r[a][HALF_W-1:0]) * VAL_W'(s2_cmag_r[a][HALF_W-1:0]);
      s3_sq_nxt[a][1] = VAL_W'(s2_cmag_r[a][HALF_W-1:0]) * VAL_W'(s2_cmag_r[a][VAL_W-1:HALF_W]);
      s3_sq_nxt[a][2] = VAL_W'(s2_cmag_r[a][VAL_W-1:HALF_W])
                      * VAL_W'(s2_cmag_r[a][VAL_W-1:HALF_W]);
      // signed sum times unsigned coefficient, in 25-bit slices
      a_lo[a] = $signed({1'b0, s2_sum_r[a][HALF_W-1:0]});
      a_hi[a] = s2_sum_r[a][SUM_W-1:HALF_W];
      b_lo[a] = $signed({1'b0, coef_a[a][HALF_W-1:0]});
      b_hi[a] = $signed({2'b00, coef_a[a][COEF_W-1:HALF_W]});
      s3_pp_nxt[a][0] = a_lo[a] * b_lo[a];
      s3_pp_nxt[a][1] = a_lo[a] * b_hi[a];
      s3_pp_nxt[a][2] = a_hi[a] * b_lo[a];
      s3_pp_nxt[a][3] = a_hi[a] * b_hi[a];
    end
  end

  always_ff @(posedge clk) begin
    s3_sq_r <= s3_sq_nxt;
    s3_pp_r <= s3_pp_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 4: assemble squares and axis products
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]          s4_sq_nxt [NAX], s4_sq_r [NAX];
  logic signed [PROD_W-1:0] s4_prod_nxt [NAX], s4_prod_r [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      s4_sq_nxt[a] = (SQ_W'(s3_sq_r[a][2]) << (2 * HALF_W))
                   + (SQ_W'(s3_sq_r[a][1]) << (HALF_W + 1))
                   + SQ_W'(s3_sq_r[a][0]);
      s4_prod_nxt[a] = (PROD_W'(s3_pp_r[a][3]) << (2 * HALF_W))
                     + ((PROD_W'(s3_pp_r[a][1]) + PROD_W'(s3_pp_r[a][2])) << HALF_W)
                     + PROD_W'(s3_pp_r[a][0]);
    end
  end

  always_ff @(posedge clk) begin
    s4_sq_r   <= s4_sq_nxt;
    s4_prod_r <= s4_prod_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 5: squared radius and stencil sum
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]          s5_r2_nxt, s5_r2_r;
  logic signed [NUMP_W-1:0] s5_nump_nxt, s5_nump_r;

  assign s5_r2_nxt   = s4_sq_r[0] + s4_sq_r[1] + s4_sq_r[2];
  assign s5_nump_nxt = NUMP_W'(s4_prod_r[0]) + NUMP_W'(s4_prod_r[1]) + NUMP_W'(s4_prod_r[2]);

  always_ff @(posedge clk) begin
    s5_r2_r   <= s5_r2_nxt;
    s5_nump_r <= s5_nump_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 6: gain times squared radius, four 24-bit slices
  // --------------------------------------------------------------------------
  localparam int NAG = SQ_W / HALF_W;

  logic [2*HALF_W-1:0]      s6_ag_nxt [NAG], s6_ag_r [NAG];
  logic signed [NUMP_W-1:0] s6_nump_r;

  always_comb begin
    for (int k = 0; k < NAG; k++) begin
      s6_ag_nxt[k] = (2*HALF_W)'(s5_r2_r[k*HALF_W +: HALF_W]) * (2*HALF_W)'(gain_a_r);
    end
  end

  always_ff @(posedge clk) begin
    s6_ag_r   <= s6_ag_nxt;
    s6_nump_r <= s5_nump_r;
  end

  // --------------------------------------------------------------------------
  // Stage 7: numerator = stencil sum + a*r^2 - 6
  // --------------------------------------------------------------------------
  logic [AR2_W-1:0]        ar2;
  logic signed [NUM_W-1:0] s7_num_nxt, s7_num_r;

  // even slices do not overlap, nor do odd ones
  assign ar2 = AR2_W'({s6_ag_r[2], s6_ag_r[0]})
             + (AR2_W'({s6_ag_r[3], s6_ag_r[1]}) << HALF_W);
  assign s7_num_nxt = NUM_W'(s6_nump_r) + $signed({2'b00, ar2}) - jsp_pkg::SIX_Q64;

  always_ff @(posedge clk) begin
    s7_num_r <= s7_num_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 8: sign and magnitude of the numerator
  // --------------------------------------------------------------------------
  logic             s8_neg_r;
  logic [MAG_W-1:0] s8_mag_nxt, s8_mag_r;

  assign s8_mag_nxt = s7_num_r[NUM_W-1] ? MAG_W'(-s7_num_r) : MAG_W'(s7_num_r);

  always_ff @(posedge clk) begin
    s8_neg_r <= s7_num_r[NUM_W-1];
    s8_mag_r <= s8_mag_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 9: magnitude slices times reciprocal halves
  // --------------------------------------------------------------------------
  logic [PADM_W-1:0] magp;
  logic [IP_W-1:0]   s9_pl_nxt [NCHK], s9_pl_r [NCHK];
  logic [IP_W-1:0]   s9_ph_nxt [NCHK], s9_ph_r [NCHK];
  logic              s9_neg_r;

  assign magp = PADM_W'(s8_mag_r);

  always_comb begin
    for (int k = 0; k < NCHK; k++) begin
      s9_pl_nxt[k] = IP_W'(magp[k*CHK_W +: CHK_W]) * IP_W'(inv_den_r[HALF_W-1:0]);
      s9_ph_nxt[k] = IP_W'(magp[k*CHK_W +: CHK_W]) * IP_W'(inv_den_r[INV_W-1:HALF_W]);
    end
  end

  always_ff @(posedge clk) begin
    s9_pl_r  <= s9_pl_nxt;
    s9_ph_r  <= s9_ph_nxt;
    s9_neg_r <= s8_neg_r;
  end

  // --------------------------------------------------------------------------
  // Stage 10: magnitude times each reciprocal half
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] s10_lo_nxt, s10_lo_r, s10_hi_nxt, s10_hi_r;
  logic             s10_neg_r;

  // even slices sit 50 bits apart and concatenate; odd ones add in once
  assign s10_lo_nxt = {1'b0, s9_pl_r[4], 1'b0, s9_pl_r[2], 1'b0, s9_pl_r[0]}
                    + (ACC_W'({1'b0, s9_pl_r[3], 1'b0, s9_pl_r[1]}) << CHK_W);
  assign s10_hi_nxt = {1'b0, s9_ph_r[4], 1'b0, s9_ph_r[2], 1'b0, s9_ph_r[0]}
                    + (ACC_W'({1'b0, s9_ph_r[3], 1'b0, s9_ph_r[1]}) << CHK_W);

  always_ff @(posedge clk) begin
    s10_lo_r  <= s10_lo_nxt;
    s10_hi_r  <= s10_hi_nxt;
    s10_neg_r <= s9_neg_r;
  end

  // --------------------------------------------------------------------------
  // Stage 11: full product, round half up on the magnitude, drop to Q.32
  // --------------------------------------------------------------------------
  logic [P_W-1:0] prod_full;
  logic [Q_W-1:0] s11_q_r;
  logic           s11_neg_r;

  assign prod_full = P_W'(s10_lo_r) + (P_W'(s10_hi_r) << HALF_W)
                   + (P_W'(1) << (RND_SH - 1));

  always_ff @(posedge clk) begin
    s11_q_r   <= prod_full[P_W-1:RND_SH];
    s11_neg_r <= s10_neg_r;
  end

  // --------------------------------------------------------------------------
  // Stage 12: apply sign and clip to the value range
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] s12_val_nxt, s12_val_r;
  logic                    s12_sat_nxt, s12_sat_r;

  always_comb begin
    s12_sat_nxt = 1'b0;
    if (!s11_neg_r) begin
      if (|s11_q_r[Q_W-1:VAL_W-1]) begin
        s12_val_nxt = jsp_pkg::VAL_MAX;
        s12_sat_nxt = 1'b1;
      end else begin
        s12_val_nxt = $signed(s11_q_r[VAL_W-1:0]);
      end
    end else begin
      // exactly 2^47 still fits as the most negative value
      if (|s11_q_r[Q_W-1:VAL_W] || (s11_q_r[VAL_W-1] && |s11_q_r[VAL_W-2:0])) begin
        s12_val_nxt = jsp_pkg::VAL_MIN;
        s12_sat_nxt = 1'b1;
      end else begin
        s12_val_nxt = -$signed(s11_q_r[VAL_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s12_val_r <= s12_val_nxt;
    s12_sat_r <= s12_sat_nxt;
  end

  // --------------------------------------------------------------------------
  // Output register: absolute change and final saturation flag
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] diff;
  logic [SUM_W-1:0]        dmag;
  logic                    chg_sat;
  logic signed [VAL_W-1:0] out_new_value_r;
  logic [COEF_W-1:0]       out_abs_change_r;
  logic                    out_saturated_r;

  assign diff    = SUM_W'(s12_val_r) - SUM_W'(prev_r[NSTG-1]);
  assign dmag    = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
  assign chg_sat = |dmag[SUM_W-1:COEF_W];

  always_ff @(posedge clk) begin
    out_new_value_r  <= s12_val_r;
    out_abs_change_r <= chg_sat ? {COEF_W{1'b1}} : dmag[COEF_W-1:0];
    out_saturated_r  <= s12_sat_r || chg_sat;
  end

  assign out_valid      = out_valid_r;
  assign out_new_value  = out_new_value_r;
  assign out_abs_change = out_abs_change_r;
  assign out_saturated  = out_saturated_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // every accepted transaction yields a result after the pipeline latency
  a_accept_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted transaction produced no result");

  // no result without a transaction accepted at the matching edge
  a_result_from_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching accepted transaction");

  // the block never refuses transactions once out of reset
  a_busy_only_in_reset : assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for jacobi_stencil_point_update
// Drives stencil points through the command channel and checks every result
// against typed values or a bit-exact predictor of the fixed-point update.
// Register settings change between phases over the APB port, and each write is
// read back. A short directed table comes first, then random points under
// several settings and sender idle ratios.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int VAL_W    = jsp_pkg::VAL_W;
  localparam int COEF_W   = jsp_pkg::COEF_W;
  localparam int INV_W    = jsp_pkg::INV_W;
  localparam int GAIN_W   = jsp_pkg::GAIN_W;
  localparam int IDX_W    = jsp_pkg::IDX_W;
  localparam int PDATA_W  = jsp_pkg::PDATA_W;
  localparam int PADDR_W  = jsp_pkg::PADDR_W;
  localparam int ADDR_LSB = jsp_pkg::ADDR_LSB;

  localparam logic signed [VAL_W-1:0] MAX_VAL  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MIN_VAL  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic        [COEF_W-1:0] MAX_CHG = '1;
  localparam logic signed [VAL_W-1:0] ONE_Q32  = 48'sh0001_0000_0000;
  localparam logic signed [VAL_W-1:0] PAT_A    = 48'sh5555_5555_5555;
  localparam logic signed [VAL_W-1:0] PAT_B    = 48'shAAAA_AAAA_AAAA;
  localparam int PHASE_ITEMS = 215;

  typedef struct {
    logic signed [VAL_W-1:0] center_prev;
    logic signed [VAL_W-1:0] x_plus;
    logic signed [VAL_W-1:0] x_minus;
    logic signed [VAL_W-1:0] y_plus;
    logic signed [VAL_W-1:0] y_minus;
    logic signed [VAL_W-1:0] z_plus;
    logic signed [VAL_W-1:0] z_minus;
    logic [IDX_W-1:0]        index_x;
    logic [IDX_W-1:0]        index_y;
    logic [IDX_W-1:0]        index_z;
  } point_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] new_value;
    logic [COEF_W-1:0]       abs_change;
    logic                    saturated;
  } point_result_t;

  typedef struct {
    point_item_t   pt;
    bit            typed;
    point_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [VAL_W-1:0] in_center_prev;
  logic signed [VAL_W-1:0] in_x_plus;
  logic signed [VAL_W-1:0] in_x_minus;
  logic signed [VAL_W-1:0] in_y_plus;
  logic signed [VAL_W-1:0] in_y_minus;
  logic signed [VAL_W-1:0] in_z_plus;
  logic signed [VAL_W-1:0] in_z_minus;
  logic [IDX_W-1:0] in_index_x;
  logic [IDX_W-1:0] in_index_y;
  logic [IDX_W-1:0] in_index_z;
  logic out_valid;
  logic signed [VAL_W-1:0] out_new_value;
  logic [COEF_W-1:0] out_abs_change;
  logic out_saturated;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Register image used by the predictor, reset values as documented
  logic [COEF_W-1:0]       cur_coef_x = 47'd10523743617024;
  logic [COEF_W-1:0]       cur_coef_y = 47'd10523743617024;
  logic [COEF_W-1:0]       cur_coef_z = 47'd10523743617024;
  logic [INV_W-1:0]        cur_inv    = 48'd277397250;
  logic [COEF_W-1:0]       cur_step   = 47'd86767016;
  logic signed [VAL_W-1:0] cur_origin = -48'sd4294967296;
  logic [GAIN_W-1:0]       cur_gain   = 24'd1000000;

  point_result_t expected_updates[$];
  dir_row_t      dir_rows[$];
  int unsigned   mismatches = 0;
  int unsigned   points_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   clipped_seen = 0;
  int unsigned   idle_pct = 0;

  jacobi_stencil_point_update i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_center_prev (in_center_prev),
    .in_x_plus      (in_x_plus),
    .in_x_minus     (in_x_minus),
    .in_y_plus      (in_y_plus),
    .in_y_minus     (in_y_minus),
    .in_z_plus      (in_z_plus),
    .in_z_minus     (in_z_minus),
    .in_index_x     (in_index_x),
    .in_index_y     (in_index_y),
    .in_index_z     (in_index_z),
    .out_valid      (out_valid),
    .out_new_value  (out_new_value),
    .out_abs_change (out_abs_change),
    .out_saturated  (out_saturated),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Exact update of one point: wide signed sums, one rounding, then clipping
  function automatic point_result_t predict_update(point_item_t p);
    logic signed [191:0] numer;
    logic signed [191:0] crd;
    logic signed [191:0] rsq;
    logic signed [191:0] diff;
    logic [191:0] mag;
    logic [191:0] q;
    logic [63:0] offs;
    logic [IDX_W-1:0] ids [3];
    logic signed [VAL_W-1:0] val;
    logic neg;
    point_result_t r;
    r.saturated = 1'b0;
    numer = (p.x_plus + p.x_minus) * $signed({1'b0, cur_coef_x})
          + (p.y_plus + p.y_minus) * $signed({1'b0, cur_coef_y})
          + (p.z_plus + p.z_minus) * $signed({1'b0, cur_coef_z});
    ids[0] = p.index_x;
    ids[1] = p.index_y;
    ids[2] = p.index_z;
    rsq = '0;
    // clip each coordinate to the value range before squaring
    for (int a = 0; a < 3; a++) begin
      offs = 64'(ids[a]) * 64'(cur_step);
      crd = cur_origin + $signed({1'b0, offs});
      if (crd > MAX_VAL) crd = MAX_VAL;
      if (crd < MIN_VAL) crd = MIN_VAL;
      rsq = rsq + crd * crd;
    end
    numer = numer + rsq * $signed({1'b0, cur_gain}) - (192'sd6 <<< 64);
    neg = numer[191];
    mag = neg ? -numer : numer;
    // Q.112 product, round half away from zero at bit 80
    q = ((mag * cur_inv) + (192'd1 << 79)) >> 80;
    if (q > (192'd1 << 47)) begin
      val = neg ? MIN_VAL : MAX_VAL;
      r.saturated = 1'b1;
    end else if (neg) begin
      val = -q[VAL_W-1:0];
    end else if (q == (192'd1 << 47)) begin
      val = MAX_VAL;
      r.saturated = 1'b1;
    end else begin
      val = q[VAL_W-1:0];
    end
    // change is taken from the clipped value
    diff = val - p.center_prev;
    mag = diff[191] ? -diff : diff;
    if (mag > MAX_CHG) begin
      mag = MAX_CHG;
      r.saturated = 1'b1;
    end
    r.new_value  = val;
    r.abs_change = mag[COEF_W-1:0];
    return r;
  endfunction

  function automatic point_item_t make_point(
    input logic signed [VAL_W-1:0] prev, xp, xm, yp, ym, zp, zm,
    input logic [IDX_W-1:0] ix, iy, iz
  );
    point_item_t p;
    p.center_prev = prev;
    p.x_plus = xp;  p.x_minus = xm;
    p.y_plus = yp;  p.y_minus = ym;
    p.z_plus = zp;  p.z_minus = zm;
    p.index_x = ix; p.index_y = iy; p.index_z = iz;
    return p;
  endfunction

  // Mix of corners, full-range words and modest values
  function automatic logic signed [VAL_W-1:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return MAX_VAL;
      1: return MIN_VAL;
      2: return '0;
      3, 4, 5: return r[VAL_W-1:0];
      default: return {{12{r[35]}}, r[35:0]};
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? '1 : '0;
    return IDX_W'($urandom_range(127));
  endfunction

  function automatic point_item_t random_point();
    return make_point(rand_value(), rand_value(), rand_value(), rand_value(),
                      rand_value(), rand_value(), rand_value(),
                      rand_index(), rand_index(), rand_index());
  endfunction

  // Random register word of the given width, scaled down by a random shift
  function automatic logic [63:0] rand_cfg(input int w);
    logic [63:0] r;
    r = {$urandom, $urandom} & ((64'd1 << w) - 1);
    return r >> $urandom_range(w);
  endfunction

  function automatic int cfg_width(input jsp_pkg::reg_idx_t r);
    case (r)
      jsp_pkg::REG_INV_DEN: return INV_W;
      jsp_pkg::REG_ORIGIN:  return VAL_W;
      jsp_pkg::REG_GAIN_A:  return GAIN_W;
      default:              return COEF_W;
    endcase
  endfunction

  function automatic logic [63:0] cfg_value(input jsp_pkg::reg_idx_t r);
    case (r)
      jsp_pkg::REG_COEF_X:  return 64'(cur_coef_x);
      jsp_pkg::REG_COEF_Y:  return 64'(cur_coef_y);
      jsp_pkg::REG_COEF_Z:  return 64'(cur_coef_z);
      jsp_pkg::REG_INV_DEN: return 64'(cur_inv);
      jsp_pkg::REG_STEP:    return 64'(cur_step);
      jsp_pkg::REG_ORIGIN:  return 64'(unsigned'(cur_origin));
      default:              return 64'(cur_gain);
    endcase
  endfunction

  // One APB transaction: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input jsp_pkg::reg_idx_t r,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {r, {ADDR_LSB{1'b0}}};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read a register back and compare the bits it implements
  task automatic check_reg(input jsp_pkg::reg_idx_t r);
    logic [PDATA_W-1:0] rd;
    logic [63:0] mask;
    mask = (64'd1 << cfg_width(r)) - 1;
    apb_access(1'b0, r, '0, rd);
    if (((rd ^ cfg_value(r)) & mask) != 0)
      report_mismatch($sformatf("register %s reads %h, want %h",
                                r.name(), rd & mask, cfg_value(r)));
  endtask

  task automatic write_reg(input jsp_pkg::reg_idx_t r, input logic [63:0] v);
    logic [PDATA_W-1:0] rd;
    case (r)
      jsp_pkg::REG_COEF_X:  cur_coef_x = v[COEF_W-1:0];
      jsp_pkg::REG_COEF_Y:  cur_coef_y = v[COEF_W-1:0];
      jsp_pkg::REG_COEF_Z:  cur_coef_z = v[COEF_W-1:0];
      jsp_pkg::REG_INV_DEN: cur_inv    = v[INV_W-1:0];
      jsp_pkg::REG_STEP:    cur_step   = v[COEF_W-1:0];
      jsp_pkg::REG_ORIGIN:  cur_origin = v[VAL_W-1:0];
      jsp_pkg::REG_GAIN_A:  cur_gain   = v[GAIN_W-1:0];
      default: ;
    endcase
    apb_access(1'b1, r, v, rd);
    check_reg(r);
  endtask

  task automatic add_row(input point_item_t p, input bit typed,
                         input logic signed [VAL_W-1:0] nv,
                         input logic [COEF_W-1:0] ch, input logic s);
    dir_row_t row;
    row.pt = p;
    row.typed = typed;
    row.want.new_value = nv;
    row.want.abs_change = ch;
    row.want.saturated = s;
    dir_rows.push_back(row);
  endtask

  // Present one point, hold it until accepted, then queue its expected result
  task automatic send_point(input dir_row_t row);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    in_center_prev = row.pt.center_prev;
    in_x_plus      = row.pt.x_plus;
    in_x_minus     = row.pt.x_minus;
    in_y_plus      = row.pt.y_plus;
    in_y_minus     = row.pt.y_minus;
    in_z_plus      = row.pt.z_plus;
    in_z_minus     = row.pt.z_minus;
    in_index_x     = row.pt.index_x;
    in_index_y     = row.pt.index_y;
    in_index_z     = row.pt.index_z;
    do @(posedge clk); while (busy);
    expected_updates.push_back(row.typed ? row.want : predict_update(row.pt));
    points_sent++;
  endtask

  // Drop start, drain the pipeline, then let the latency pass
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    start = 1'b0;
    while (expected_updates.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    point_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_saturated) clipped_seen++;
      if (expected_updates.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want = expected_updates.pop_front();
        if (out_new_value !== want.new_value)
          report_mismatch($sformatf("result %0d new_value %h, want %h",
                                    results_seen, out_new_value, want.new_value));
        if (out_abs_change !== want.abs_change)
          report_mismatch($sformatf("result %0d abs_change %h, want %h",
                                    results_seen, out_abs_change, want.abs_change));
        if (out_saturated !== want.saturated)
          report_mismatch($sformatf("result %0d saturated %b, want %b",
                                    results_seen, out_saturated, want.saturated));
      end
    end
  end

  initial begin
    jsp_pkg::reg_idx_t r;
    dir_row_t row;
    rst_n = 1'b0;
    start = 1'b0;
    in_center_prev = '0;
    in_x_plus = '0;
    in_x_minus = '0;
    in_y_plus = '0;
    in_y_minus = '0;
    in_z_plus = '0;
    in_z_minus = '0;
    in_index_x = '0;
    in_index_y = '0;
    in_index_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every register must hold its reset value
    r = r.first();
    do begin
      check_reg(r);
      r = r.next();
    end while (r != r.first());

    // Directed setting: largest coefficients and reciprocal, unit gain
    write_reg(jsp_pkg::REG_COEF_X, 64'(MAX_CHG));
    write_reg(jsp_pkg::REG_COEF_Y, 64'(MAX_CHG));
    write_reg(jsp_pkg::REG_COEF_Z, 64'(MAX_CHG));
    write_reg(jsp_pkg::REG_INV_DEN, {16'd0, {INV_W{1'b1}}});
    write_reg(jsp_pkg::REG_GAIN_A, 64'd1);

    // Clipping of the value and of the change, typed in
    add_row(make_point('0, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0, 0, 0),
            1, MAX_VAL, MAX_CHG, 1'b1);
    add_row(make_point('0, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0, 0, 0),
            1, MIN_VAL, MAX_CHG, 1'b1);
    add_row(make_point(MIN_VAL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL,
                       127, 127, 127), 1, MAX_VAL, MAX_CHG, 1'b1);
    add_row(make_point(MAX_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL,
                       127, 127, 127), 1, MIN_VAL, MAX_CHG, 1'b1);
    // Border indices, extreme previous values, bit patterns, small operands
    add_row(make_point('0, '0, '0, '0, '0, '0, '0, 0, 0, 0), 0, '0, '0, 1'b0);
    add_row(make_point('0, '0, '0, '0, '0, '0, '0, 127, 127, 127), 0, '0, '0, 1'b0);
    add_row(make_point(MAX_VAL, '0, '0, '0, '0, '0, '0, 127, 0, 64), 0, '0, '0, 1'b0);
    add_row(make_point(MIN_VAL, '0, '0, '0, '0, '0, '0, 0, 127, 1), 0, '0, '0, 1'b0);
    add_row(make_point(ONE_Q32, 48'sd1, -48'sd1, 48'sd1, -48'sd1, 48'sd1, -48'sd1, 3, 5, 7),
            0, '0, '0, 1'b0);
    add_row(make_point(-ONE_Q32, MAX_VAL, MIN_VAL, '0, '0, '0, '0, 64, 64, 64),
            0, '0, '0, 1'b0);
    add_row(make_point(PAT_A, PAT_A, PAT_B, PAT_B, PAT_A, PAT_A, PAT_B, 85, 42, 85),
            0, '0, '0, 1'b0);
    add_row(make_point(PAT_B, PAT_B, PAT_A, PAT_A, PAT_B, PAT_B, PAT_A, 42, 85, 42),
            0, '0, '0, 1'b0);
    add_row(make_point('0, '0, '0, '0, '0, MAX_VAL, MAX_VAL, 1, 1, 1), 0, '0, '0, 1'b0);
    add_row(make_point('0, '0, '0, MIN_VAL, MIN_VAL, '0, '0, 126, 2, 99), 0, '0, '0, 1'b0);
    add_row(make_point(ONE_Q32, 48'sd2, 48'sd1, -48'sd3, 48'sd0, 48'sd1, 48'sd1, 10, 20, 30),
            0, '0, '0, 1'b0);
    add_row(make_point(-48'sd1, -48'sd1, -48'sd1, -48'sd1, -48'sd1, -48'sd1, -48'sd1,
                       49, 50, 51), 0, '0, '0, 1'b0);

    foreach (dir_rows[i]) send_point(dir_rows[i]);

    // Random points under several register settings and sender idle ratios
    row.typed = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(jsp_pkg::REG_COEF_X, 64'd10523743617024);
          write_reg(jsp_pkg::REG_COEF_Y, 64'd10523743617024);
          write_reg(jsp_pkg::REG_COEF_Z, 64'd10523743617024);
          write_reg(jsp_pkg::REG_INV_DEN, 64'd277397250);
          write_reg(jsp_pkg::REG_STEP, 64'd86767016);
          write_reg(jsp_pkg::REG_ORIGIN, -64'sd4294967296);
          write_reg(jsp_pkg::REG_GAIN_A, 64'd1000000);
          idle_pct = 0;
        end
        1: begin
          r = r.first();
          do begin
            write_reg(r, 64'd0);
            r = r.next();
          end while (r != r.first());
          idle_pct = 73;
        end
        2: begin
          // coordinates beyond the value range get clipped before squaring
          write_reg(jsp_pkg::REG_STEP, 64'(MAX_CHG));
          write_reg(jsp_pkg::REG_ORIGIN, 64'(MAX_VAL));
          write_reg(jsp_pkg::REG_GAIN_A, 64'd1);
          write_reg(jsp_pkg::REG_INV_DEN, 64'd277397250);
          write_reg(jsp_pkg::REG_COEF_X, 64'd10523743617024);
          write_reg(jsp_pkg::REG_COEF_Y, 64'd42949672960);
          write_reg(jsp_pkg::REG_COEF_Z, 64'd4294967296);
          idle_pct = 0;
        end
        3: begin
          write_reg(jsp_pkg::REG_COEF_X, 64'(MAX_CHG));
          write_reg(jsp_pkg::REG_COEF_Y, 64'(MAX_CHG));
          write_reg(jsp_pkg::REG_COEF_Z, 64'(MAX_CHG));
          write_reg(jsp_pkg::REG_INV_DEN, {16'd0, {INV_W{1'b1}}});
          write_reg(jsp_pkg::REG_STEP, 64'(MAX_CHG));
          write_reg(jsp_pkg::REG_ORIGIN, {{16{1'b1}}, MIN_VAL});
          write_reg(jsp_pkg::REG_GAIN_A, {40'd0, {GAIN_W{1'b1}}});
          idle_pct = 37;
        end
        default: begin
          r = r.first();
          do begin
            if (r == jsp_pkg::REG_ORIGIN)
              write_reg(r, 64'($signed(48'({$urandom, $urandom})) >>> $urandom_range(47)));
            else
              write_reg(r, rand_cfg(cfg_width(r)));
            r = r.next();
          end while (r != r.first());
          idle_pct = (ph == 4) ? 73 : 37;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        row.pt = random_point();
        send_point(row);
      end
    end

    // Drain, then flag anything still outstanding
    settle();
    if (expected_updates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_updates.size()));

    $display("Checked %0d stencil point updates (%0d clipped) over 7 register settings,",
             points_sent, clipped_seen);
    $display("with sender idle ratios of 0, 37 and 73 percent and register read-back.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
